### hw/rtl/lfp_pkg.sv
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared constants and helpers for the lagged Fibonacci word source.
// ----------------------------------------------------------------------------
`default_nettype none

package lfp_pkg;

   localparam int LONG_LAG   = 17;
   localparam int SHORT_LAG  = 5;
   localparam int WORD_BITS  = 31;
   localparam int MUL_BITS   = 15;
   localparam int BIN_BITS   = 5;
   localparam int PTR_BITS   = $clog2(LONG_LAG);
   localparam int CNT_BITS   = $clog2(LONG_LAG + 1);
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [MUL_BITS-1:0] MULTIPLIER = MUL_BITS'(16807);

   // register index decode: byte address 4*i, index taken from paddr[2]
   localparam logic CSR_IDX_SEED = 1'b0;

   localparam logic [WORD_BITS-1:0] SEED_RESET = WORD_BITS'(1);

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [PTR_BITS-1:0]  ptr_type;

   // floor(v*20/2^WORD_BITS) == floor(v*5/2^(WORD_BITS-2))
   function automatic logic [BIN_BITS-1:0] bin_of(input word_type v);
      logic [WORD_BITS+2:0] prod;
      prod = {1'b0, v, 2'b00} + {3'b000, v};
      return prod[WORD_BITS+2:WORD_BITS-2];
   endfunction

   // next pointer around the circular history
   function automatic ptr_type ptr_add(input ptr_type p, input ptr_type k);
      logic [PTR_BITS:0] sum;
      sum = {1'b0, p} + {1'b0, k};
      if (sum >= (PTR_BITS + 1)'(LONG_LAG)) begin
         sum = sum - (PTR_BITS + 1)'(LONG_LAG);
      end
      return sum[PTR_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/lagged_fibonacci_prng_unit.sv
// ----------------------------------------------------------------------------
// lagged_fibonacci_prng_unit
// Additive lagged Fibonacci word source, lags 17 and 5, with uniform bin.
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  req       in   req_valid / req_stall   req_request
//  rsp       out  rsp_valid / rsp_stall   rsp_value, rsp_bin
//  csr       in   APB psel/penable        seed at byte address 0
//
//  One request per cycle while req_stall is low; a response passes the word stage, then the output register.
//  Word stage prefetches its taps from the 17-entry history RAM via next pointer.
//  Reset clears control; the RAM needs no clearing, the fill count gates it.
//  Response stall backs up into req_stall only once the word stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module lagged_fibonacci_prng_unit
   import lfp_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire                      req_request,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic [WORD_BITS-1:0]     rsp_value,
   output logic [BIN_BITS-1:0]      rsp_bin,
   input  wire                      csr_psel,
   input  wire                      csr_penable,
   input  wire                      csr_pwrite,
   input  wire [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire [CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   word_type seed_ff;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   ptr_type  wp_ff, wp_in;
   word_type prev_ff;
   logic     s1_valid_ff, s1_valid_in;
   word_type s1_word_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_value_ff;
   logic [BIN_BITS-1:0] rsp_bin_ff;

   logic     take_req;
   logic     gen;
   logic     out_free;
   logic     csr_wr;
   word_type word;
   word_type lag_long;
   word_type lag_short;
   ptr_type  rd_addr_b;
   word_type mul_prod;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else if (csr_wr && (csr_paddr[2] == CSR_IDX_SEED)) begin
         seed_ff <= csr_pwdata[WORD_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_SEED) begin
         csr_prdata = CSR_DATA_BITS'(seed_ff);
      end
   end

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_free;
   assign take_req  = req_valid && !req_stall;
   assign gen       = take_req && req_request;

   // word generation
   assign mul_prod = prev_ff * WORD_BITS'(MULTIPLIER);

   always_comb begin
      if (cnt_ff == '0) begin
         word = seed_ff;
      end else if (cnt_ff < CNT_BITS'(LONG_LAG)) begin
         word = mul_prod;
      end else begin
         word = lag_long + lag_short;
      end
   end

   always_comb begin
      wp_in  = wp_ff;
      cnt_in = cnt_ff;
      if (gen) begin
         wp_in = ptr_add(wp_ff, PTR_BITS'(1));
         if (cnt_ff < CNT_BITS'(LONG_LAG)) begin
            cnt_in = cnt_ff + CNT_BITS'(1);
         end
      end
   end

   // prefetch the two taps of the next word
   assign rd_addr_b = ptr_add(wp_in, PTR_BITS'(LONG_LAG - SHORT_LAG));

   lfp_hist_ram u_hist (
      .clock     (clock),
      .wr_en     (gen),
      .wr_addr   (wp_ff),
      .wr_data   (word),
      .rd_addr_a (wp_in),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (lag_long),
      .rd_data_b (lag_short)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (gen) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         wp_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         wp_ff        <= wp_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (gen) begin
         prev_ff    <= word;
         s1_word_ff <= word;
      end
      if (out_free && s1_valid_ff) begin
         rsp_value_ff <= s1_word_ff;
         rsp_bin_ff   <= bin_of(s1_word_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_bin   = rsp_bin_ff;

   // checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(LONG_LAG))
      else $error("fill count past long lag");

   a_ptr_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff < CNT_BITS'(LONG_LAG)) |-> (CNT_BITS'(wp_ff) == cnt_ff))
      else $error("write pointer out of step with fill count");

   a_gen_loads_stage: assert property (@(posedge clock) disable iff (reset)
      gen |=> s1_valid_ff)
      else $error("accepted request lost in word stage");

endmodule

`default_nettype wire

### hw/rtl/lfp_hist_ram.sv
// ----------------------------------------------------------------------------
// lfp_hist_ram
// History store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module lfp_hist_ram
   import lfp_pkg::*;
(
   input  wire      clock,
   input  wire      wr_en,
   input  ptr_type  wr_addr,
   input  word_type wr_data,
   input  ptr_type  rd_addr_a,
   input  ptr_type  rd_addr_b,
   output word_type rd_data_a,
   output word_type rd_data_b
);

   word_type hist_mem [LONG_LAG];
   word_type rd_a_ff;
   word_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= hist_mem[rd_addr_a];
      rd_b_ff <= hist_mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for lagged_fibonacci_prng_unit. It writes and reads back the seed
// register, including a masked wide write and a write to an unmapped address.
// It then issues directed and random word requests, with no-op requests mixed
// in, under random sender gaps and response stalls. A tracker predicts every
// word and bin through the seed, congruential and lagged-sum phases. It checks
// each response in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top
   import lfp_pkg::*;
();

   localparam logic [CSR_ADDR_BITS-1:0] SEED_ADDR   = CSR_ADDR_BITS'(0);
   localparam logic [CSR_ADDR_BITS-1:0] UNUSED_ADDR = CSR_ADDR_BITS'(4);
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 10;

   typedef struct packed {
      word_type            value;
      logic [BIN_BITS-1:0] bin;
   } word_result_type;

   class lfp_word_tracker;
      word_type          seed_reg;
      word_type          history [LONG_LAG];
      int unsigned       produced;
      word_result_type   expected_words [$];
      int unsigned       mismatches;
      int unsigned       checked;

      function new();
         seed_reg = SEED_RESET;
         foreach (history[k]) history[k] = '0;
         produced = 0;
         mismatches = 0;
         checked = 0;
      endfunction

      function void write_seed(logic [CSR_DATA_BITS-1:0] data);
         seed_reg = data[WORD_BITS-1:0];
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction

      function void note_request(bit request);
         word_type             w;
         logic [45:0]          prod;
         logic [36:0]          scaled;
         word_result_type      e;
         if (!request) return;
         if (produced == 0) begin
            w = seed_reg;
         end else if (produced < LONG_LAG) begin
            prod = 46'(history[0]) * 46'(MULTIPLIER);
            w = prod[WORD_BITS-1:0];
         end else begin
            w = history[LONG_LAG-1] + history[SHORT_LAG-1];
         end
         for (int k = LONG_LAG - 1; k > 0; k--) history[k] = history[k-1];
         history[0] = w;
         if (produced < LONG_LAG) produced++;
         scaled = 37'(w) * 37'd20;
         e.value = w;
         e.bin = scaled[35:31];
         expected_words.push_back(e);
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         mismatches++;
         $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
      endtask

      task check_word(word_type v, logic [BIN_BITS-1:0] b);
         word_result_type e;
         if (expected_words.size() == 0) begin
            report("response with nothing expected", v, 0);
            return;
         end
         e = expected_words.pop_front();
         checked++;
         if (v !== e.value) report("value", v, e.value);
         if (b !== e.bin) report("bin", b, e.bin);
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_request = 1'b1;
   logic                     rsp_stall = 1'b0;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   wire                      req_stall;
   wire                      rsp_valid;
   wire  [WORD_BITS-1:0]     rsp_value;
   wire  [BIN_BITS-1:0]      rsp_bin;
   wire  [CSR_DATA_BITS-1:0] csr_prdata;
   wire                      csr_pready;

   lfp_word_tracker tracker = new();

   int unsigned cycles = 0;
   int unsigned word_reqs = 0;
   int unsigned noop_reqs = 0;
   int unsigned seed_writes = 0;
   bit          no_idle = 1'b0;
   bit          send_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   int unsigned stall_left = 0;

   lagged_fibonacci_prng_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_request (req_request),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_value   (rsp_value),
      .rsp_bin     (rsp_bin),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycles, tracker.pending());
         $display("TB_ERROR");
         $finish;
      end
   end

   // check responses and drive response stall bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_word(rsp_value, rsp_bin);
      if (cycles % 50 == 0) rsp_idle_on = ($urandom_range(0, 3) != 0);
      if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!reset && !no_idle && rsp_idle_on && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_request(input bit request);
      req_valid <= 1'b1;
      req_request <= request;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(request);
      if (request) word_reqs++;
      else noop_reqs++;
   endtask

   task automatic sender_gap();
      if (!no_idle && send_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // hold off until every expected word has come, then let the pipe drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr[2] == CSR_IDX_SEED) begin
         tracker.write_seed(data);
         seed_writes++;
      end
      @(posedge clock);
   endtask

   task automatic csr_read_seed();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= SEED_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[WORD_BITS-1:0] !== tracker.seed_reg)
         tracker.report("seed readback", csr_prdata, tracker.seed_reg);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned sent;
      sent = 0;
      while (sent < count) begin
         if (sent % 64 == 0) send_idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) begin
            send_request(1'b0);
         end else begin
            send_request(1'b1);
            sent++;
         end
         sender_gap();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(SEED_ADDR, '0);
      csr_read_seed();
      csr_write(UNUSED_ADDR, $urandom());
      csr_read_seed();
      // top bit must be masked off
      csr_write(SEED_ADDR, 32'hFFFF_FFFF);
      csr_read_seed();

      // seed word, congruential fill, lagged sums, no-op requests in between
      send_request(1'b0);
      for (int k = 0; k < 22; k++) begin
         send_request(1'b1);
         if (k == 8 || k == 17) send_request(1'b0);
         if (k == 12) begin
            req_valid <= 1'b0;
            repeat (3) @(posedge clock);
         end
      end

      settle();
      // new seed must not restart the sequence
      csr_write(SEED_ADDR, '0);
      csr_read_seed();
      run_random(450);

      settle();
      csr_write(SEED_ADDR, $urandom());
      csr_read_seed();
      csr_write(UNUSED_ADDR, $urandom());
      csr_read_seed();
      run_random(450);

      settle();
      csr_write(SEED_ADDR, 32'h7FFF_FFFF);
      csr_read_seed();
      run_random(300);
      no_idle = 1'b1;
      run_random(180);

      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d word requests, %0d no-op requests, %0d seed writes",
               word_reqs, noop_reqs, seed_writes);
      $display("responses checked: %0d, mismatches: %0d",
               tracker.checked, tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
